@@ rtl/owbt_pkg.sv @@
// Shared types and constants of the one-wire brightness transmitter.
package owbt_pkg;

    localparam int CFG_WIDTH       = 16;
    localparam int NUM_REGS        = 8;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int TIMER_WIDTH     = CFG_WIDTH;
    localparam int LEVEL_WIDTH     = 8;
    localparam int DATA_BITS       = 5;

    localparam logic [7:0] DEVICE_ADDRESS = 8'h72;

    // Register indexes.
    localparam logic [2:0] REG_SHORT        = 3'd0;
    localparam logic [2:0] REG_LONG         = 3'd1;
    localparam logic [2:0] REG_END_OF_STREAM = 3'd2;
    localparam logic [2:0] REG_START        = 3'd3;
    localparam logic [2:0] REG_OFF          = 3'd4;
    localparam logic [2:0] REG_ENTRY_DELAY  = 3'd5;
    localparam logic [2:0] REG_ENTRY_DETECT = 3'd6;
    localparam logic [2:0] REG_ENTRY_WINDOW = 3'd7;

    typedef logic [NUM_REGS-1:0][CFG_WIDTH-1:0] t_cfg_regs;

    localparam t_cfg_regs CFG_RESET = {
        16'd1000, 16'd286, 16'd190, 16'd4000, 16'd4, 16'd4, 16'd7, 16'd3
    };

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_OFF      = 9'b000000010,
        PH_DELAY    = 9'b000000100,
        PH_DETECT   = 9'b000001000,
        PH_WINDOW   = 9'b000010000,
        PH_BIT_LOW  = 9'b000100000,
        PH_BIT_HIGH = 9'b001000000,
        PH_EOS      = 9'b010000000,
        PH_START    = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic pin_out;
        logic busy_res;
        logic rejected;
    } t_result;

endpackage

@@ rtl/owbt_if.sv @@
// Channel interfaces: request input, result output and configuration write.
interface owbt_in_if;
    import owbt_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [LEVEL_WIDTH-1:0] level;
    modport source (output valid, output cmd, output level, input ready);
    modport sink   (input valid, input cmd, input level, output ready);
endinterface

interface owbt_out_if;
    logic valid;
    logic ready;
    logic pin_out;
    logic busy_res;
    logic rejected;
    modport source (output valid, output pin_out, output busy_res, output rejected, input ready);
    modport sink   (input valid, input pin_out, input busy_res, input rejected, output ready);
endinterface

interface owbt_cfg_if;
    import owbt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_WIDTH-1:0]       data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/owbt_cfg_regs.sv @@
// Timing register file, written through the configuration channel.
module owbt_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    owbt_cfg_if.sink            i_cfg,
    output owbt_pkg::t_cfg_regs o_cfg
);
    import owbt_pkg::*;

    t_cfg_regs r_cfg;

    assign i_cfg.ready = 1'b1;

    // Indexes past the last register are accepted and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && (i_cfg.index < CFG_INDEX_WIDTH'(NUM_REGS))) begin
            r_cfg[i_cfg.index[2:0]] <= i_cfg.data;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/owbt_seq.sv @@
// Phase sequencer with tick timer and bit shifter; produces one result per beat.
module owbt_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_beat,
    input  logic                         i_cmd,
    input  logic [owbt_pkg::LEVEL_WIDTH-1:0] i_level,
    input  owbt_pkg::t_cfg_regs          i_cfg,
    output owbt_pkg::t_result            o_result
);
    import owbt_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_time_left, n_time_left;
    logic [2:0]             r_bit_index, n_bit_index;
    logic [7:0]             r_shift, n_shift;
    logic [DATA_BITS-1:0]   r_pending, n_pending;
    logic                   r_byte_sel, n_byte_sel;
    logic                   r_last_on, n_last_on;
    logic                   r_pin, n_pin;
    logic                   n_rejected;
    logic [7:0]             shifted;

    assign shifted = {r_shift[6:0], 1'b0};

    always_comb begin
        n_phase     = r_phase;
        n_time_left = r_time_left;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_pending   = r_pending;
        n_byte_sel  = r_byte_sel;
        n_last_on   = r_last_on;
        n_pin       = r_pin;
        n_rejected  = 1'b0;
        if (i_beat) begin
            if (i_cmd) begin
                if (r_phase != PH_IDLE) begin
                    n_rejected = 1'b1;
                end else if (i_level == '0) begin
                    n_pin     = 1'b0;
                    n_last_on = 1'b0;
                end else begin
                    n_pending  = i_level[DATA_BITS-1:0];
                    n_byte_sel = 1'b0;
                    n_pin      = 1'b0;
                    if (!r_last_on) begin
                        n_phase     = PH_OFF;
                        n_time_left = i_cfg[REG_OFF];
                    end else begin
                        // Light already on: skip mode entry, start the address byte.
                        n_shift     = DEVICE_ADDRESS;
                        n_bit_index = '0;
                        n_phase     = PH_BIT_LOW;
                        n_time_left = DEVICE_ADDRESS[7] ? i_cfg[REG_SHORT] : i_cfg[REG_LONG];
                    end
                    n_last_on = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                if (r_time_left > TIMER_WIDTH'(1)) begin
                    n_time_left = r_time_left - TIMER_WIDTH'(1);
                end else begin
                    case (r_phase)
                        PH_OFF: begin
                            n_phase     = PH_DELAY;
                            n_pin       = 1'b1;
                            n_time_left = i_cfg[REG_ENTRY_DELAY];
                        end
                        PH_DELAY: begin
                            n_phase     = PH_DETECT;
                            n_pin       = 1'b0;
                            n_time_left = i_cfg[REG_ENTRY_DETECT];
                        end
                        PH_DETECT: begin
                            n_phase     = PH_WINDOW;
                            n_pin       = 1'b1;
                            n_time_left = i_cfg[REG_ENTRY_WINDOW];
                        end
                        PH_WINDOW: begin
                            n_byte_sel  = 1'b0;
                            n_shift     = DEVICE_ADDRESS;
                            n_bit_index = '0;
                            n_phase     = PH_BIT_LOW;
                            n_pin       = 1'b0;
                            n_time_left = DEVICE_ADDRESS[7] ? i_cfg[REG_SHORT] : i_cfg[REG_LONG];
                        end
                        PH_BIT_LOW: begin
                            n_phase     = PH_BIT_HIGH;
                            n_pin       = 1'b1;
                            n_time_left = r_shift[7] ? i_cfg[REG_LONG] : i_cfg[REG_SHORT];
                        end
                        PH_BIT_HIGH: begin
                            if (r_bit_index == 3'd7) begin
                                n_phase     = PH_EOS;
                                n_pin       = 1'b0;
                                n_time_left = i_cfg[REG_END_OF_STREAM];
                            end else begin
                                n_bit_index = r_bit_index + 3'd1;
                                n_shift     = shifted;
                                n_phase     = PH_BIT_LOW;
                                n_pin       = 1'b0;
                                n_time_left = shifted[7] ? i_cfg[REG_SHORT] : i_cfg[REG_LONG];
                            end
                        end
                        PH_EOS: begin
                            n_phase     = PH_START;
                            n_pin       = 1'b1;
                            n_time_left = i_cfg[REG_START];
                        end
                        PH_START: begin
                            if (!r_byte_sel) begin
                                // The data byte has its top three bits clear.
                                n_byte_sel  = 1'b1;
                                n_shift     = {3'b000, r_pending};
                                n_bit_index = '0;
                                n_phase     = PH_BIT_LOW;
                                n_pin       = 1'b0;
                                n_time_left = i_cfg[REG_LONG];
                            end else begin
                                n_phase     = PH_IDLE;
                                n_time_left = '0;
                            end
                        end
                        default: begin
                            n_phase     = PH_IDLE;
                            n_time_left = '0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_bit_index <= '0;
            r_shift     <= '0;
            r_pending   <= '0;
            r_byte_sel  <= 1'b0;
            r_last_on   <= 1'b0;
            r_pin       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_time_left <= n_time_left;
            r_bit_index <= n_bit_index;
            r_shift     <= n_shift;
            r_pending   <= n_pending;
            r_byte_sel  <= n_byte_sel;
            r_last_on   <= n_last_on;
            r_pin       <= n_pin;
        end
    end

    assign o_result.pin_out  = n_pin;
    assign o_result.busy_res = (n_phase != PH_IDLE);
    assign o_result.rejected = n_rejected;

endmodule

@@ rtl/one_wire_brightness_transmitter_top.sv @@
// Top level of the one-wire brightness transmitter.
// Each input beat is either one time tick or a brightness request and yields exactly one
// result beat, presented from an output register in the cycle after the input beat.
// The block takes one input beat per clock; it stalls only while the output register holds
// a result that the sink has not taken, so the rate is set by output back-pressure alone.
// The sequencer state and the result register are updated together at each accepted beat.
// Timing registers are written through the configuration channel, which is always ready.
module one_wire_brightness_transmitter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owbt_in_if.sink    i_in,
    owbt_out_if.source o_out,
    owbt_cfg_if.sink   i_cfg
);
    import owbt_pkg::*;

    t_cfg_regs cfg;
    t_result   seq_result;
    t_result   r_result;
    logic      r_out_valid;
    logic      beat;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign beat       = i_in.valid && i_in.ready;

    owbt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    owbt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .i_cmd    (i_in.cmd),
        .i_level  (i_in.level),
        .i_cfg    (cfg),
        .o_result (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat) begin
            r_result <= seq_result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.pin_out  = r_result.pin_out;
    assign o_out.busy_res = r_result.busy_res;
    assign o_out.rejected = r_result.rejected;

    // A rejected request leaves the transmission running.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rejected) |-> o_out.busy_res)
        else $error("rejected result without busy");

    // No input beat may overwrite a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !(i_in.valid && i_in.ready))
        else $error("input accepted while result stalled");

    // Every input beat produces a result beat in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("no result after input beat");

endmodule
